// ----- hdl/i2ctcr_pkg.sv -----
// ----------------------------------------------------------------------------
// i2ctcr_pkg
// Shared types and constants of the I2C target command receiver: event codes,
// parser phases and the register map of the configuration port.
// ----------------------------------------------------------------------------
package i2ctcr_pkg;

	// event codes on the input channel
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_POP   = 2'd2,
		CMD_FLUSH = 2'd3
	} cmd_t;

	// write-frame parser phases
	typedef enum logic [4:0] {
		PH_ADDR = 5'b00001,
		PH_CMD  = 5'b00010,
		PH_D0   = 5'b00100,
		PH_D1   = 5'b01000,
		PH_IDLE = 5'b10000
	} phase_t;

	// bus widths
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned OWN_ADDR_W = 7;
	localparam int unsigned VALUE_W    = 16;
	localparam int unsigned ENTRY_W    = BYTE_W + VALUE_W;

	// configuration port: one 32-bit register at byte address 0
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_OWN_ADDR = 1'b0;

	// read/write bit of an address byte
	localparam logic [BYTE_W-1:0] RW_BIT_MASK = 8'h01;

endpackage

// ----- hdl/i2c_target_command_receiver.sv -----
// ----------------------------------------------------------------------------
// i2c_target_command_receiver
// Byte-level I2C write-frame target with a command queue for firmware.
// ----------------------------------------------------------------------------
// Each input item is one event: a start condition, a completed bus byte, a
// pop request or a queue flush; each item gives exactly one result item.
// Start, byte, flush and a pop on an empty queue need no memory read, so
// such items can be accepted on every clock while no pop read is pending and
// no result is held stalled. A pop that returns an entry reads the queue, a
// synchronous memory with a registered read, and the input is stalled until
// the read data comes back. The result waits in an output register, so a new
// item is accepted while the previous result is still being taken. No
// clearing pass runs after reset; entries are read only once they have been
// written. Write own_address only while no item is in flight.
module i2c_target_command_receiver #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// event channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           cmd,
	input  logic [i2ctcr_pkg::BYTE_W-1:0]        bus_byte,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 drive_ack,
	output logic                                 await_start,
	output logic                                 frame_stored,
	output logic                                 queue_overflow,
	output logic                                 pop_valid,
	output logic [i2ctcr_pkg::BYTE_W-1:0]        pop_command,
	output logic [i2ctcr_pkg::VALUE_W-1:0]       pop_value,
	output logic                                 queue_not_empty,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [i2ctcr_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [i2ctcr_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [i2ctcr_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                 pready
);
	import i2ctcr_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	// configuration register
	logic [OWN_ADDR_W-1:0] own_addr_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  cfg_wr;

	// parser state
	phase_t                phase_q, phase_d;
	logic [BYTE_W-1:0]     held_cmd_q, held_cmd_d;
	logic [BYTE_W-1:0]     held_low_q, held_low_d;

	// queue state
	logic [ENTRY_W-1:0]    queue_mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0]    rd_data_q;
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rd_pend_q;
	logic                  pend_not_empty_q;

	// output register
	logic                  out_valid_q;
	logic                  ack_q, await_q, stored_q, ovf_q, pop_valid_q, not_empty_q;
	logic [BYTE_W-1:0]     pop_cmd_q;
	logic [VALUE_W-1:0]    pop_val_q;

	// per-item decode
	logic                  acc;
	logic                  push, pop_rd, flush;
	logic                  r_ack, r_await, r_stored, r_ovf, r_not_empty;
	logic                  addr_hit;

	assign acc      = in_valid && !in_stall;
	assign in_stall = rd_pend_q || (out_valid_q && out_stall);
	assign addr_hit = (bus_byte == '0) || (bus_byte[BYTE_W-1:1] == own_addr_q);

	// configuration port
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_OWN_ADDR) begin
			prdata = APB_DATA_W'(own_addr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
		end else if (cfg_wr && reg_idx == REG_OWN_ADDR) begin
			own_addr_q <= pwdata[OWN_ADDR_W-1:0];
		end
	end

	// event decode and frame parser
	always_comb begin
		phase_d    = phase_q;
		held_cmd_d = held_cmd_q;
		held_low_d = held_low_q;
		push       = 1'b0;
		pop_rd     = 1'b0;
		flush      = 1'b0;
		r_ack      = 1'b0;
		r_await    = 1'b0;
		r_stored   = 1'b0;
		r_ovf      = 1'b0;
		if (acc) begin
			unique case (cmd_t'(cmd))
				CMD_START: begin
					phase_d = PH_ADDR;
				end
				CMD_BYTE: begin
					unique case (phase_q)
						PH_ADDR: begin
							if (addr_hit) begin
								r_ack   = 1'b1;
								phase_d = ((bus_byte & RW_BIT_MASK) != '0) ? PH_IDLE : PH_CMD;
							end else begin
								r_await = 1'b1;
								phase_d = PH_IDLE;
							end
						end
						PH_CMD: begin
							held_cmd_d = bus_byte;
							r_ack      = 1'b1;
							phase_d    = PH_D0;
						end
						PH_D0: begin
							held_low_d = bus_byte;
							r_ack      = 1'b1;
							phase_d    = PH_D1;
						end
						PH_D1: begin
							r_ack   = 1'b1;
							r_await = 1'b1;
							phase_d = PH_IDLE;
							if (cnt_q == CNT_FULL) begin
								r_ovf = 1'b1;
							end else begin
								push     = 1'b1;
								r_stored = 1'b1;
							end
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase
				end
				CMD_POP: begin
					pop_rd = (cnt_q != '0);
				end
				CMD_FLUSH: begin
					flush = 1'b1;
				end
			endcase
		end
	end

	// occupancy after this item
	always_comb begin
		if (flush) begin
			r_not_empty = 1'b0;
		end else if (push) begin
			r_not_empty = 1'b1;
		end else if (pop_rd) begin
			r_not_empty = (cnt_q != CNT_ONE);
		end else begin
			r_not_empty = (cnt_q != '0);
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ADDR;
			held_cmd_q <= '0;
			held_low_q <= '0;
		end else begin
			phase_q    <= phase_d;
			held_cmd_q <= held_cmd_d;
			held_low_q <= held_low_d;
		end
	end

	// queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else if (flush) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else if (push) begin
			wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			cnt_q    <= cnt_q + CNT_ONE;
		end else if (pop_rd) begin
			rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			cnt_q    <= cnt_q - CNT_ONE;
		end
	end

	// queue memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (push) begin
			queue_mem[wr_ptr_q] <= {held_cmd_q, bus_byte, held_low_q};
		end
		if (pop_rd) begin
			rd_data_q <= queue_mem[rd_ptr_q];
		end
	end

	// pop read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q        <= 1'b0;
			pend_not_empty_q <= 1'b0;
		end else begin
			rd_pend_q <= pop_rd;
			if (pop_rd) begin
				pend_not_empty_q <= r_not_empty;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_q || (acc && !pop_rd)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			ack_q       <= 1'b0;
			await_q     <= 1'b0;
			stored_q    <= 1'b0;
			ovf_q       <= 1'b0;
			pop_valid_q <= 1'b1;
			pop_cmd_q   <= rd_data_q[ENTRY_W-1 -: BYTE_W];
			pop_val_q   <= rd_data_q[VALUE_W-1:0];
			not_empty_q <= pend_not_empty_q;
		end else if (acc && !pop_rd) begin
			ack_q       <= r_ack;
			await_q     <= r_await;
			stored_q    <= r_stored;
			ovf_q       <= r_ovf;
			pop_valid_q <= 1'b0;
			pop_cmd_q   <= '0;
			pop_val_q   <= '0;
			not_empty_q <= r_not_empty;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_ack       = ack_q;
	assign await_start     = await_q;
	assign frame_stored    = stored_q;
	assign queue_overflow  = ovf_q;
	assign pop_valid       = pop_valid_q;
	assign pop_command     = pop_cmd_q;
	assign pop_value       = pop_val_q;
	assign queue_not_empty = not_empty_q;

	// count never passes the queue depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("queue count above depth");

	// returning read data always finds the output register free
	a_pend_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !out_valid_q)
		else $error("pop data collides with a held result");

	// a pop read completes next cycle and its result is registered the cycle after
	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop_rd |=> ##1 (out_valid_q && pop_valid_q))
		else $error("pop read did not produce a result");

	// a popped result carries no parser flags
	a_pop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pop_valid_q) |-> !(ack_q || await_q || stored_q || ovf_q))
		else $error("pop result mixed with parser flags");

	// a frame is either stored or dropped, never both
	a_store_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(stored_q && ovf_q))
		else $error("frame both stored and dropped");

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C target command receiver. Bus events (start,
// byte, pop, flush) are queued by the stimulus process and driven on the event
// channel. Every accepted event is run through a local copy of the frame
// parser and command queue, and each result item is compared with the oldest
// prediction. own_address is rewritten between phases, and both channels
// idle at changing rates.
// ----------------------------------------------------------------------------
module testbench;
	import i2ctcr_pkg::*;

	localparam int FIFO_DEPTH = 16;

	typedef struct packed {
		cmd_t             code;
		logic [BYTE_W-1:0] data;
	} bus_event_t;

	typedef struct packed {
		logic               ack;
		logic               await_s;
		logic               stored;
		logic               ovf;
		logic               pv;
		logic [BYTE_W-1:0]  pcmd;
		logic [VALUE_W-1:0] pval;
		logic               qne;
	} reply_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// event channel
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            cmd      = 2'd0;
	logic [BYTE_W-1:0]     bus_byte = '0;

	// result channel
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  drive_ack;
	logic                  await_start;
	logic                  frame_stored;
	logic                  queue_overflow;
	logic                  pop_valid;
	logic [BYTE_W-1:0]     pop_command;
	logic [VALUE_W-1:0]    pop_value;
	logic                  queue_not_empty;

	// configuration port
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// stimulus and prediction bookkeeping
	bus_event_t bus_events[$];
	reply_t     receiver_replies[$];
	int         events_offered   = 0;
	int         events_taken     = 0;
	int         event_total      = 0;
	int         mismatches       = 0;
	int         send_idle_pct    = 0;
	int         recv_idle_pct    = 0;
	int         hold_cycles_left = 0;

	// local copy of the parser and queue
	logic [OWN_ADDR_W-1:0] own_addr_model = '0;
	phase_t                parse_phase    = PH_ADDR;
	logic [2:0]            frame_bytes    = '0;
	logic [BYTE_W-1:0]     cmd_latch      = '0;
	logic [BYTE_W-1:0]     low_latch      = '0;
	logic [BYTE_W-1:0]     fifo_cmd[FIFO_DEPTH];
	logic [VALUE_W-1:0]    fifo_val[FIFO_DEPTH];
	int                    wr_ptr         = 0;
	int                    rd_ptr         = 0;
	int                    fill           = 0;

	i2c_target_command_receiver #(
		.QUEUE_DEPTH(FIFO_DEPTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.bus_byte       (bus_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_ack      (drive_ack),
		.await_start    (await_start),
		.frame_stored   (frame_stored),
		.queue_overflow (queue_overflow),
		.pop_valid      (pop_valid),
		.pop_command    (pop_command),
		.pop_value      (pop_value),
		.queue_not_empty(queue_not_empty),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// clock
	always #5 clk = ~clk;

	// next queue slot, wrapping at the depth
	function automatic int slot_after(input int p);
		return (p + 1 >= FIFO_DEPTH) ? 0 : p + 1;
	endfunction

	// one event through the parser and queue, giving the reply it causes
	function automatic reply_t receiver_reply(input cmd_t code, input logic [BYTE_W-1:0] data);
		reply_t r;
		r = '0;
		case (code)
			CMD_START: begin
				parse_phase = PH_ADDR;
				frame_bytes = 3'd0;
			end
			CMD_BYTE: begin
				case (parse_phase)
					PH_ADDR: begin
						if (data == '0 || data[BYTE_W-1:1] == own_addr_model) begin
							r.ack       = 1'b1;
							frame_bytes = 3'd0;
							parse_phase = ((data & RW_BIT_MASK) != '0) ? PH_IDLE : PH_CMD;
						end else begin
							r.await_s   = 1'b1;
							parse_phase = PH_IDLE;
						end
					end
					PH_CMD: begin
						cmd_latch   = data;
						frame_bytes = 3'd1;
						r.ack       = 1'b1;
						parse_phase = PH_D0;
					end
					PH_D0: begin
						low_latch   = data;
						frame_bytes = 3'd2;
						r.ack       = 1'b1;
						parse_phase = PH_D1;
					end
					PH_D1: begin
						frame_bytes = 3'd3;
						r.ack       = 1'b1;
						r.await_s   = 1'b1;
						parse_phase = PH_IDLE;
						if (fill >= FIFO_DEPTH) begin
							r.ovf = 1'b1;
						end else begin
							fifo_cmd[wr_ptr] = cmd_latch;
							fifo_val[wr_ptr] = {data, low_latch};
							wr_ptr           = slot_after(wr_ptr);
							fill++;
							r.stored         = 1'b1;
						end
					end
					default: begin
						parse_phase = PH_IDLE;
					end
				endcase
			end
			CMD_POP: begin
				if (fill != 0) begin
					r.pv   = 1'b1;
					r.pcmd = fifo_cmd[rd_ptr];
					r.pval = fifo_val[rd_ptr];
					rd_ptr = slot_after(rd_ptr);
					fill--;
				end
			end
			default: begin
				wr_ptr = 0;
				rd_ptr = 0;
				fill   = 0;
			end
		endcase
		r.qne = (fill != 0);
		return r;
	endfunction

	// report one differing field
	task automatic check_field(input string field, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// driver: offers the next queued event once the current one is taken
	always @(negedge clk) begin
		bus_event_t next_ev;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || events_taken == events_offered) begin
			if (bus_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_ev  = bus_events.pop_front();
				cmd      <= next_ev.code;
				bus_byte <= next_ev.data;
				in_valid <= 1'b1;
				events_offered++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with a long hold-off counted down here
	always @(negedge clk) begin
		if (hold_cycles_left > 0) begin
			out_stall <= 1'b1;
			hold_cycles_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: check taken results, then predict newly taken events
	always @(posedge clk) begin
		reply_t seen;
		reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = '{drive_ack, await_start, frame_stored, queue_overflow,
					pop_valid, pop_command, pop_value, queue_not_empty};
				if (receiver_replies.size() == 0) begin
					$display("%0t: result with none expected, got %h", $time, seen);
					mismatches++;
				end else begin
					want = receiver_replies.pop_front();
					check_field("drive_ack", 16'(want.ack), 16'(seen.ack));
					check_field("await_start", 16'(want.await_s), 16'(seen.await_s));
					check_field("frame_stored", 16'(want.stored), 16'(seen.stored));
					check_field("queue_overflow", 16'(want.ovf), 16'(seen.ovf));
					check_field("pop_valid", 16'(want.pv), 16'(seen.pv));
					check_field("pop_command", 16'(want.pcmd), 16'(seen.pcmd));
					check_field("pop_value", want.pval, seen.pval);
					check_field("queue_not_empty", 16'(want.qne), 16'(seen.qne));
				end
			end
			if (in_valid && !in_stall) begin
				receiver_replies.push_back(receiver_reply(cmd_t'(cmd), bus_byte));
				events_taken++;
			end
		end
	end

	// queue one event
	task automatic add_event(input cmd_t code, input logic [BYTE_W-1:0] data);
		bus_events.push_back('{code, data});
		event_total++;
	endtask

	// start, address and three frame bytes
	task automatic add_frame(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] c,
		input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
		add_event(CMD_START, BYTE_W'($urandom_range(255)));
		add_event(CMD_BYTE, addr);
		add_event(CMD_BYTE, c);
		add_event(CMD_BYTE, lo);
		add_event(CMD_BYTE, hi);
	endtask

	// mostly well-formed frames and pops, some broken frames and noise
	task automatic add_random_traffic(input int count);
		int                stop_at;
		int                pick;
		logic [BYTE_W-1:0] b;
		stop_at = event_total + count;
		while (event_total < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				b = ($urandom_range(9) == 0) ? 8'h00 : {own_addr_model, 1'b0};
				add_frame(b, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
					BYTE_W'($urandom_range(255)));
			end else if (pick < 70) begin
				repeat ($urandom_range(3, 1)) add_event(CMD_POP, BYTE_W'($urandom_range(255)));
			end else if (pick < 73) begin
				add_event(CMD_FLUSH, BYTE_W'($urandom_range(255)));
			end else if (pick < 88) begin
				// broken frame: cut short, wrong address or read address
				add_event(CMD_START, BYTE_W'($urandom_range(255)));
				case ($urandom_range(2))
					0: b = {own_addr_model, 1'b0};
					1: begin
						do b = BYTE_W'($urandom_range(255, 1));
						while (b[BYTE_W-1:1] == own_addr_model);
					end
					default: b = {own_addr_model, 1'b1};
				endcase
				add_event(CMD_BYTE, b);
				repeat ($urandom_range(2, 1)) add_event(CMD_BYTE, BYTE_W'($urandom_range(255)));
			end else begin
				add_event(cmd_t'($urandom_range(3)), BYTE_W'($urandom_range(255)));
			end
		end
	endtask

	// wait until every queued event is taken and every result has come
	task automatic wait_drained;
		while (!(bus_events.size() == 0 && events_taken == events_offered &&
			receiver_replies.size() == 0)) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write: setup then access cycle
	task automatic write_own_address(input logic [OWN_ADDR_W-1:0] addr);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_OWN_ADDR, 2'b00};
		pwdata  <= APB_DATA_W'(addr);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		own_addr_model = addr;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// stimulus sequence
	initial begin
		send_idle_pct = 28;
		recv_idle_pct = 54;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: pop on empty, general call frame with extreme bytes
		add_event(CMD_POP, 8'hFF);
		add_frame(8'h00, 8'hFF, 8'h00, 8'hFF);
		// read address, then a byte that is ignored
		add_event(CMD_START, 8'h00);
		add_event(CMD_BYTE, 8'h01);
		add_event(CMD_BYTE, 8'hAA);
		// wrong address, then a byte that is ignored
		add_event(CMD_START, 8'hFF);
		add_event(CMD_BYTE, 8'hFE);
		add_event(CMD_BYTE, 8'h55);
		// start in the middle of a frame abandons it
		add_event(CMD_START, 8'h00);
		add_event(CMD_BYTE, 8'h00);
		add_event(CMD_BYTE, 8'h12);
		add_frame(8'h00, 8'h34, 8'h56, 8'h78);
		// two pops, pop on empty, flush
		add_event(CMD_POP, 8'h00);
		add_event(CMD_POP, 8'h80);
		add_event(CMD_POP, 8'h7F);
		add_event(CMD_FLUSH, 8'h00);
		wait_drained();

		// top address, sender idling less than receiver
		write_own_address(7'h7F);
		add_random_traffic(600);
		wait_drained();

		// mid address, roles swapped, with a long receiver hold-off
		send_idle_pct = 54;
		recv_idle_pct = 28;
		write_own_address(OWN_ADDR_W'($urandom_range(126, 1)));
		add_random_traffic(600);
		repeat (60) @(posedge clk);
		hold_cycles_left = 300;
		wait_drained();

		// zero address, no idling, sender pauses halfway until all results are in
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_own_address(7'h00);
		add_random_traffic(300);
		wait_drained();
		add_random_traffic(300);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && receiver_replies.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/i2ctcr_pkg.sv
hdl/i2c_target_command_receiver.sv
sim/testbench.sv
